FILE: rtl/core/lfg_pkg.sv
// ----------------------------------------------------------------------------
// LED frame generator package
// Shared types, codes, sizes and the sine table for the frame generator.
// ----------------------------------------------------------------------------
package lfg_pkg;

    localparam int PalDepth = 64;
    localparam int PalAw    = $clog2(PalDepth);
    localparam int CntW     = $clog2(PalDepth + 1);
    localparam int MaxLeds  = 64;
    localparam int LedW     = 6;
    localparam int NW       = 7;
    localparam int DvdW     = 49;
    localparam int DsrW     = 9;
    localparam int QuoW     = 16;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_FRAME  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    localparam logic [3:0] MODE_FADE  = 4'd1;
    localparam logic [3:0] MODE_BLINK = 4'd2;
    localparam logic [3:0] MODE_WALK  = 4'd3;
    localparam logic [3:0] MODE_WINK  = 4'd4;
    localparam logic [3:0] MODE_SINE  = 4'd5;

    localparam logic CFG_ANIM_MODE    = 1'b0;
    localparam logic CFG_STRIP_LENGTH = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] color_in;
    } in_item_t;

    typedef struct packed {
        logic [31:0]     pixel_color;
        logic [LedW-1:0] pixel_index;
        logic            last_pixel;
    } out_item_t;

    typedef struct packed {
        cmd_t        kind;
        logic [31:0] color;
    } op_t;

    typedef enum logic [2:0] {
        PX_PASS,
        PX_DARK,
        PX_DIM,
        PX_SINE,
        PX_BLACK
    } px_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV1,
        BK_DIV2,
        BK_RUN
    } back_state_t;

    typedef struct packed {
        logic            start;
        logic [DvdW-1:0] dividend;
        logic [DsrW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic            busy;
        logic [QuoW-1:0] quotient;
        logic [DsrW-1:0] remainder;
    } div_rsp_t;

    localparam logic [7:0] QSINE [0:64] = '{
        8'd0, 8'd3, 8'd6, 8'd9, 8'd13, 8'd16, 8'd19, 8'd22,
        8'd25, 8'd28, 8'd31, 8'd34, 8'd37, 8'd40, 8'd43, 8'd46,
        8'd49, 8'd52, 8'd55, 8'd58, 8'd60, 8'd63, 8'd66, 8'd68,
        8'd71, 8'd74, 8'd76, 8'd79, 8'd81, 8'd84, 8'd86, 8'd88,
        8'd91, 8'd93, 8'd95, 8'd97, 8'd99, 8'd101, 8'd103, 8'd105,
        8'd106, 8'd108, 8'd110, 8'd111, 8'd113, 8'd114, 8'd116, 8'd117,
        8'd118, 8'd119, 8'd121, 8'd122, 8'd122, 8'd123, 8'd124, 8'd125,
        8'd126, 8'd126, 8'd127, 8'd127, 8'd127, 8'd128, 8'd128, 8'd128,
        8'd128
    };

    // Intensity 128 + 128*sin in Q1.8, built from the quarter wave.
    function automatic logic [8:0] intensity(input logic [7:0] k);
        logic [7:0] q;
        if (k <= 8'd64) begin
            q = QSINE[k[6:0]];
            return 9'd128 + {1'b0, q};
        end
        else if (k <= 8'd128) begin
            q = QSINE[7'(8'd128 - k)];
            return 9'd128 + {1'b0, q};
        end
        else if (k <= 8'd192) begin
            q = QSINE[7'(k - 8'd128)];
            return 9'd128 - {1'b0, q};
        end
        else begin
            q = QSINE[7'(8'd0 - k)];
            return 9'd128 - {1'b0, q};
        end
    endfunction

    function automatic logic [3:0] triangle(input logic [4:0] p);
        return (p >= 5'd8) ? 4'(5'd16 - p) : p[3:0];
    endfunction

endpackage

FILE: rtl/core/lfg_div.sv
// ----------------------------------------------------------------------------
// LED frame generator divider
// Restoring divider, one quotient bit per cycle, low quotient bits kept.
// ----------------------------------------------------------------------------
module lfg_div (
    input  logic             clk,
    input  logic             rst_n,
    input  lfg_pkg::div_req_t req,
    output lfg_pkg::div_rsp_t rsp
);
    import lfg_pkg::*;

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic [DvdW-1:0] dvd_reg, dvd_next;
    logic [DsrW-1:0] dsr_reg, dsr_next;
    logic [DsrW-1:0] rem_reg, rem_next;
    logic [QuoW-1:0] quo_reg, quo_next;
    logic [DsrW:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, dvd_reg[DvdW-1]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg) begin
            dvd_next = {dvd_reg[DvdW-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = DsrW'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[QuoW-2:0], 1'b1};
            end
            else begin
                rem_next = trial[DsrW-1:0];
                quo_next = {quo_reg[QuoW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(DvdW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.busy      = busy_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: rtl/core/lfg_front.sv
// ----------------------------------------------------------------------------
// LED frame generator front end
// Accepts commands, drops no-operations and queues the rest for the back end.
// ----------------------------------------------------------------------------
module lfg_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lfg_pkg::in_item_t in_data,
    output logic              op_valid,
    input  logic              op_pop,
    output lfg_pkg::op_t      op
);
    import lfg_pkg::*;

    op_t        q_mem [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic       push;
    logic       pop;
    op_t        new_op;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready && (cmd_t'(in_data.command) != CMD_NOP);
    assign pop      = op_pop && (cnt_reg != 2'd0);
    assign new_op   = '{kind: cmd_t'(in_data.command), color: in_data.color_in};

    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else begin
            cnt_reg <= cnt_next;
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            q_mem[wr_reg] <= new_op;
        end
    end

    assign op_valid = (cnt_reg != 2'd0);
    assign op       = q_mem[rd_reg];

endmodule

FILE: rtl/core/lfg_back.sv
// ----------------------------------------------------------------------------
// LED frame generator back end
// Keeps palette, phase; runs frames, emits a pixel per cycle when not stalled.
// ----------------------------------------------------------------------------
module lfg_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    output logic               op_pop,
    input  lfg_pkg::op_t       op,
    input  logic [3:0]         anim_mode,
    input  logic [6:0]         strip_n,
    output lfg_pkg::div_req_t  div_req,
    input  lfg_pkg::div_rsp_t  div_rsp,
    output logic               out_valid,
    input  logic               out_ready,
    output lfg_pkg::out_item_t out_data
);
    import lfg_pkg::*;

    logic [31:0]      pal_mem [PalDepth];
    logic [31:0]      mem_rd_reg;

    back_state_t      state_reg, state_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic [31:0]      phase_reg, phase_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [3:0]       mode_reg, mode_next;
    logic [LedW-1:0]  i_reg, i_next;
    logic [PalAw-1:0] cidx_reg, cidx_next;
    logic [PalAw-1:0] sidx_reg, sidx_next;
    logic [15:0]      q1_reg, q1_next;
    logic [5:0]       r1_reg, r1_next;
    logic [15:0]      stq_reg, stq_next;
    logic [5:0]       str_reg, str_next;
    logic [5:0]       d1_reg, d1_next;
    logic [15:0]      t2_reg, t2_next;

    logic             s1_valid_reg, s1_valid_next;
    px_kind_t         s1_kind_reg, s1_kind;
    logic [3:0]       s1_shift_reg, s1_shift;
    logic [8:0]       s1_m_reg;
    logic [LedW-1:0]  s1_index_reg;
    logic             s1_last_reg;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg;

    logic             out_free;
    logic             issue;
    logic             last_issue;
    logic             pal_wr;
    logic [PalAw-1:0] rd_addr;
    logic [31:0]      phase_wrap;
    logic [6:0]       r1_sum;
    logic [15:0]      k_sum;
    logic [8:0]       m_val;
    logic [31:0]      px;
    logic [16:0]      pr, pg, pb;

    assign out_free   = !out_valid_reg || out_ready;
    assign issue      = (state_reg == BK_RUN) && (!s1_valid_reg || out_free);
    assign last_issue = issue && ({1'b0, i_reg} == NW'(n_reg - 7'd1));
    assign rd_addr    = (mode_reg == MODE_SINE) ? sidx_reg : cidx_reg;
    assign k_sum      = q1_reg + t2_reg;
    assign m_val      = intensity(k_sum[15:8]);
    // Both remainders stay below the divisor, so the sum needs one extra bit.
    assign r1_sum     = {1'b0, r1_reg} + {1'b0, str_reg};

    always_comb
    begin
        phase_wrap = phase_reg;
        if (anim_mode == MODE_FADE && phase_reg > 32'd7) begin
            phase_wrap = '0;
        end
        if (anim_mode == MODE_BLINK && phase_reg > 32'd16) begin
            phase_wrap = '0;
        end
        if (anim_mode == MODE_WINK && phase_reg > {25'd0, strip_n}) begin
            phase_wrap = '0;
        end
    end

    // Control sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        n_next     = n_reg;
        mode_next  = mode_reg;
        i_next     = i_reg;
        cidx_next  = cidx_reg;
        sidx_next  = sidx_reg;
        q1_next    = q1_reg;
        r1_next    = r1_reg;
        stq_next   = stq_reg;
        str_next   = str_reg;
        d1_next    = d1_reg;
        t2_next    = t2_reg;
        op_pop     = 1'b0;
        pal_wr     = 1'b0;
        div_req    = '{start: 1'b0, dividend: '0, divisor: '0};
        unique case (state_reg)
            BK_IDLE:
            begin
                if (op_valid) begin
                    op_pop = 1'b1;
                    unique case (op.kind)
                        CMD_APPEND:
                        begin
                            if (count_reg < CntW'(PalDepth)) begin
                                pal_wr     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            phase_next = '0;
                        end
                        CMD_FRAME:
                        begin
                            n_next     = strip_n;
                            mode_next  = anim_mode;
                            phase_next = phase_wrap;
                            i_next     = '0;
                            sidx_next  = '0;
                            cidx_next  = (count_reg == CntW'(1)) ? '0 : PalAw'(1);
                            q1_next    = '0;
                            r1_next    = '0;
                            d1_next    = (strip_n == 7'd1) ? 6'd1 : 6'(strip_n - 7'd1);
                            if (anim_mode == MODE_SINE) begin
                                div_req.start    = 1'b1;
                                div_req.dividend = DvdW'(65536);
                                div_req.divisor  = (strip_n == 7'd1) ? DsrW'(1)
                                                   : DsrW'(strip_n - 7'd1);
                                state_next       = BK_DIV1;
                            end
                            else begin
                                state_next = BK_RUN;
                            end
                        end
                        CMD_NOP:
                        begin
                        end
                    endcase
                end
            end
            BK_DIV1:
            begin
                if (div_rsp.done) begin
                    stq_next = (n_reg == 7'd1) ? '0 : div_rsp.quotient;
                    str_next = (n_reg == 7'd1) ? '0 : div_rsp.remainder[5:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = {phase_reg, 17'd0};
                    div_req.divisor  = DsrW'({n_reg, 2'b00}) + DsrW'(n_reg);
                    state_next       = BK_DIV2;
                end
            end
            BK_DIV2:
            begin
                if (div_rsp.done) begin
                    t2_next    = div_rsp.quotient;
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (issue) begin
                    i_next    = i_reg + 1'b1;
                    cidx_next = ({1'b0, cidx_reg} + 1'b1 == count_reg) ? '0
                                : cidx_reg + 1'b1;
                    sidx_next = ({1'b0, sidx_reg} + 1'b1 == count_reg) ? '0
                                : sidx_reg + 1'b1;
                    if (r1_sum >= {1'b0, d1_reg}) begin
                        r1_next = 6'(r1_sum - {1'b0, d1_reg});
                        q1_next = q1_reg + stq_reg + 16'd1;
                    end
                    else begin
                        r1_next = r1_sum[5:0];
                        q1_next = q1_reg + stq_reg;
                    end
                    if (last_issue) begin
                        if (mode_reg >= MODE_FADE && mode_reg <= MODE_SINE) begin
                            phase_next = phase_reg + 32'd1;
                        end
                        state_next = BK_IDLE;
                    end
                end
            end
        endcase
    end

    // Per-pixel treatment chosen at issue
    always_comb
    begin
        s1_shift = '0;
        s1_kind  = PX_PASS;
        if (count_reg == '0) begin
            s1_kind = PX_BLACK;
        end
        else begin
            unique case (mode_reg)
                MODE_FADE:
                begin
                    s1_kind  = PX_DIM;
                    s1_shift = phase_reg[3:0];
                end
                MODE_BLINK:
                begin
                    s1_kind  = PX_DIM;
                    s1_shift = triangle(phase_reg[4:0]);
                end
                MODE_WALK:
                begin
                    s1_kind  = PX_DIM;
                    s1_shift = triangle({1'b0, phase_reg[3:0] + i_reg[3:0]});
                end
                MODE_WINK:
                begin
                    s1_kind = (phase_reg == {26'd0, i_reg}) ? PX_DARK : PX_PASS;
                end
                MODE_SINE:
                begin
                    s1_kind = PX_SINE;
                end
                default:
                begin
                    s1_kind = PX_PASS;
                end
            endcase
        end
    end

    // Output formatting from the registered palette word
    always_comb
    begin
        pr = mem_rd_reg[23:16] * s1_m_reg;
        pg = mem_rd_reg[15:8] * s1_m_reg;
        pb = mem_rd_reg[7:0] * s1_m_reg;
        unique case (s1_kind_reg)
            PX_PASS:  px = mem_rd_reg;
            PX_DARK:  px = '0;
            PX_BLACK: px = '0;
            PX_DIM:   px = {8'd0, mem_rd_reg[23:16] >> s1_shift_reg,
                            mem_rd_reg[15:8] >> s1_shift_reg,
                            mem_rd_reg[7:0] >> s1_shift_reg};
            PX_SINE:  px = {8'd0, pr[15:8], pg[15:8], pb[15:8]};
            default:  px = '0;
        endcase
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (issue) begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            phase_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        mode_reg <= mode_next;
        i_reg    <= i_next;
        cidx_reg <= cidx_next;
        sidx_reg <= sidx_next;
        q1_reg   <= q1_next;
        r1_reg   <= r1_next;
        stq_reg  <= stq_next;
        str_reg  <= str_next;
        d1_reg   <= d1_next;
        t2_reg   <= t2_next;
        if (issue) begin
            s1_kind_reg  <= s1_kind;
            s1_shift_reg <= s1_shift;
            s1_m_reg     <= m_val;
            s1_index_reg <= i_reg;
            s1_last_reg  <= last_issue;
        end
        if (out_free && s1_valid_reg) begin
            out_reg <= '{pixel_color: px, pixel_index: s1_index_reg,
                         last_pixel: s1_last_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_wr) begin
            pal_mem[count_reg[PalAw-1:0]] <= op.color;
        end
        if (issue) begin
            mem_rd_reg <= pal_mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(PalDepth))
        else $error("palette count above depth");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == BK_DIV1 || state_reg == BK_DIV2))
        else $error("divider finished outside a divide step");

    a_run_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_RUN) |-> ({1'b0, i_reg} < n_reg))
        else $error("pixel counter ran past the strip");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        last_issue |=> (state_reg == BK_IDLE))
        else $error("frame did not end after its last pixel");

endmodule

FILE: rtl/core/led_animation_frame_generator.sv
// ----------------------------------------------------------------------------
// LED animation frame generator
// Palette-driven frame generator with fade, blink, walk, wink and sine modes.
// ----------------------------------------------------------------------------
//  Channel | Signals                                  | Transfer when
//  --------+------------------------------------------+-----------------------
//  in      | in_valid, in_ready, in_data              | in_valid && in_ready
//  out     | out_valid, out_ready, out_data           | out_valid && out_ready
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| cfg_valid && cfg_ready
//
// Append and clear commands are handled in the back end's idle state. A frame
// of n LEDs streams one pixel per cycle while the output is not stalled; in
// sine mode the restoring divider first runs two divisions before the first
// pixel.
// Reset clears the palette count, the phase and all handshake state; the
// palette memory itself is not cleared. A stalled output holds the pixel
// pipeline, and the two-entry command queue keeps accepting until it fills.
module led_animation_frame_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lfg_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lfg_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data
);
    import lfg_pkg::*;

    logic [3:0] mode_reg;
    logic [6:0] length_reg;
    logic [6:0] strip_n;
    logic       op_valid;
    logic       op_pop;
    op_t        op;
    div_req_t   div_req;
    div_rsp_t   div_rsp;

    // Configuration registers are always ready; a frame latches the mode and
    // length in effect when it starts.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= 4'd0;
            length_reg <= 7'd16;
        end
        else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ANIM_MODE:    mode_reg   <= cfg_data[3:0];
                CFG_STRIP_LENGTH: length_reg <= cfg_data[6:0];
            endcase
        end
    end

    // A length of zero means one LED, and lengths beyond the strip saturate.
    assign strip_n = (length_reg == 7'd0) ? 7'd1
                   : (length_reg > 7'(MaxLeds)) ? 7'(MaxLeds) : length_reg;

    lfg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .op_valid (op_valid),
        .op_pop   (op_pop),
        .op       (op)
    );

    lfg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    lfg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_pop    (op_pop),
        .op        (op),
        .anim_mode (mode_reg),
        .strip_n   (strip_n),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: sim/lfg_checker.sv
// ----------------------------------------------------------------------------
// LED frame generator checker
// Watches the command, pixel and register channels, predicts every pixel of
// every frame and compares the pixel stream field by field.
// ----------------------------------------------------------------------------
module lfg_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  lfg_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  lfg_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lfg_pkg::*;

    logic [31:0] colors [0:PalDepth-1];
    logic [6:0]  color_count;
    logic [31:0] phase;
    logic [3:0]  mode;
    logic [6:0]  strip_len;
    out_item_t   expected_pixels [$];

    assign pending = expected_pixels.size();

    task automatic report(input string what);
        $display("%0t ns: pixel mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic logic [31:0] dim(input logic [31:0] c, input int s);
        int sh;
        sh = (s > 8) ? 8 : s;
        return {8'd0, 8'(c[23:16] >> sh), 8'(c[15:8] >> sh), 8'(c[7:0] >> sh)};
    endfunction

    function automatic int bend(input int p);
        return (p >= 8) ? 16 - p : p;
    endfunction

    function automatic int sine_level(input int k);
        if (k <= 64)
            return 128 + QSINE[k];
        else if (k <= 128)
            return 128 + QSINE[128 - k];
        else if (k <= 192)
            return 128 - QSINE[k - 128];
        return 128 - QSINE[256 - k];
    endfunction

    // Works out the whole frame for the current palette, mode and phase.
    task automatic queue_frame();
        int              n;
        int              len;
        logic [31:0]     ph;
        logic [31:0]     c;
        logic [31:0]     cs;
        logic [31:0]     px;
        longint unsigned t1;
        longint unsigned t2;
        int              m;
        out_item_t       item;
        n = (strip_len == 0) ? 1 : ((strip_len > MaxLeds) ? MaxLeds : int'(strip_len));
        len = color_count;
        if (mode == MODE_FADE && phase > 7)
            phase = 0;
        if (mode == MODE_BLINK && phase > 16)
            phase = 0;
        if (mode == MODE_WINK && phase > n)
            phase = 0;
        ph = phase;
        for (int i = 0; i < n; i++)
        begin
            px = '0;
            if (len != 0)
            begin
                c = colors[(i + 1) % len];
                case (mode)
                    MODE_FADE:  px = dim(c, int'(ph));
                    MODE_BLINK: px = dim(c, bend(int'(ph)));
                    MODE_WALK:  px = dim(c, bend(int'((ph + i) & 32'hf)));
                    MODE_WINK:  px = (ph == i) ? 32'd0 : c;
                    MODE_SINE:
                    begin
                        cs = colors[i % len];
                        t1 = (n > 1) ? (longint'(i) * 65536) / longint'(n - 1) : 0;
                        t2 = (longint'(ph) * 131072) / longint'(n * 5);
                        m = sine_level(int'(((t1 + t2) & 64'hffff) >> 8));
                        px = {8'd0, 8'((cs[23:16] * m) >> 8), 8'((cs[15:8] * m) >> 8),
                              8'((cs[7:0] * m) >> 8)};
                    end
                    default:    px = c;
                endcase
            end
            item.pixel_color = px;
            item.pixel_index = LedW'(i);
            item.last_pixel  = (i == n - 1);
            expected_pixels.push_back(item);
        end
        if (mode >= MODE_FADE && mode <= MODE_SINE)
            phase = ph + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            color_count = 0;
            phase = 0;
            mode = 0;
            strip_len = 16;
            fail_count = 0;
            expected_pixels.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ANIM_MODE)
                    mode = cfg_data[3:0];
                else
                    strip_len = cfg_data[6:0];
            end
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                    report($sformatf("unexpected pixel %h", out_data));
                else
                begin
                    want = expected_pixels.pop_front();
                    if (out_data.pixel_color !== want.pixel_color)
                        report($sformatf("color %h, want %h (led %0d)",
                            out_data.pixel_color, want.pixel_color, want.pixel_index));
                    if (out_data.pixel_index !== want.pixel_index)
                        report($sformatf("index %0d, want %0d",
                            out_data.pixel_index, want.pixel_index));
                    if (out_data.last_pixel !== want.last_pixel)
                        report($sformatf("last flag %b, want %b (led %0d)",
                            out_data.last_pixel, want.last_pixel, want.pixel_index));
                end
            end
            if (in_valid && in_ready)
            begin
                case (in_data.command)
                    CMD_APPEND:
                    begin
                        if (color_count < PalDepth)
                        begin
                            colors[color_count] = in_data.color_in;
                            color_count++;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        color_count = 0;
                        phase = 0;
                    end
                    CMD_FRAME: queue_frame();
                    default: ;
                endcase
            end
        end
    end
endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// LED frame generator testbench
// Drives commands and register writes into the frame generator with random
// gaps and output stalls; the checker beside the block predicts the pixels.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lfg_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_index;
    logic [7:0] cfg_data;
    int        fail_count;
    int        pending;

    // While calm is set neither side idles.
    bit        calm;
    // The stimulus raises hold_req; the receiver then stalls for a long stretch.
    bit        hold_req;
    int        hold_left;
    int        sent;

    led_animation_frame_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lfg_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Generous limit: the slowest correct run is far below this.
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // The receiver stalls at random, except when calm, and holds off entirely
    // for a long counted stretch when asked, so that the command queue fills
    // and the block stops taking commands.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= 38);
        end
    end

    // One command transfer, with random idle cycles ahead of it.
    task automatic send_command(input cmd_t kind, input logic [31:0] color);
        while (!calm && $urandom_range(0, 99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.command  <= kind;
        in_data.color_in <= color;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
    endtask

    // Register writes happen only with the block idle, so the stream is
    // stopped first and the pipeline is allowed to drain completely.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Upper data bits are don't-care, so they are filled at random.
    task automatic set_mode_len(input logic [3:0] m, input logic [6:0] len);
        settle();
        write_reg(CFG_ANIM_MODE, {4'($urandom), m});
        write_reg(CFG_STRIP_LENGTH, {1'($urandom), len});
    endtask

    task automatic random_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            send_command(CMD_APPEND, $urandom);
        else if (r < 75)
            send_command(CMD_FRAME, $urandom);
        else if (r < 85)
            send_command(CMD_CLEAR, $urandom);
        else
            send_command(CMD_NOP, $urandom);
    endtask

    initial
    begin
        logic [6:0] len;
        int         phase_no;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        sent      = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Reset settings first: a frame from an empty palette
        // must come out black, and a no-operation must produce nothing.
        send_command(CMD_FRAME, 32'h0);
        send_command(CMD_NOP, 32'hffff_ffff);
        send_command(CMD_APPEND, 32'hffff_ffff);
        send_command(CMD_APPEND, 32'h0000_0000);
        send_command(CMD_APPEND, 32'ha5c3_0f81);
        send_command(CMD_FRAME, 32'h0);
        // An unused mode code behaves as normal; length zero is one LED.
        set_mode_len(4'd15, 7'd0);
        send_command(CMD_FRAME, 32'h0);
        set_mode_len(MODE_FADE, 7'd64);
        send_command(CMD_FRAME, 32'h0);
        send_command(CMD_FRAME, 32'h0);
        // A length above the strip size saturates.
        set_mode_len(MODE_BLINK, 7'd127);
        send_command(CMD_FRAME, 32'h0);
        set_mode_len(MODE_WALK, 7'd5);
        send_command(CMD_FRAME, 32'h0);
        send_command(CMD_FRAME, 32'h0);
        // Enough wink frames for the dark LED to wrap around the strip.
        set_mode_len(MODE_WINK, 7'd3);
        repeat (5) send_command(CMD_FRAME, 32'h0);
        set_mode_len(MODE_SINE, 7'd1);
        send_command(CMD_FRAME, 32'h0);
        set_mode_len(MODE_SINE, 7'd64);
        send_command(CMD_FRAME, 32'h0);
        send_command(CMD_CLEAR, 32'h0);
        send_command(CMD_FRAME, 32'h0);

        // Random phases, each with its own register settings. The first four
        // phases always run so that every pressure case is reached.
        phase_no = 0;
        while (sent < 150 || phase_no < 4)
        begin
            len = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(1, 8));
            if (phase_no == 3)
                len = 7'd30;
            set_mode_len(4'($urandom_range(0, 15)), len);
            calm = (phase_no == 1);
            if (phase_no == 2)
            begin
                // Overfill the palette: appends past the last entry are dropped.
                send_command(CMD_CLEAR, $urandom);
                repeat (70) send_command(CMD_APPEND, $urandom);
            end
            if (phase_no == 3)
            begin
                hold_req = 1'b1;
                repeat (6) send_command(CMD_FRAME, $urandom);
            end
            repeat ($urandom_range(5, 15)) random_command();
            calm = 1'b0;
            phase_no++;
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
